@@ rtl/lavm_pkg.sv @@
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared types and constants for the look-at view matrix builder.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int LAVM_FRAC_BITS_DEF = 16;
  // magnitude width fed into the normalizer
  localparam int LAVM_MAG_W = 62;
  // normalized magnitude width, top bit lands at bit 29
  localparam int LAVM_NRM_W = 30;
  localparam int LAVM_COLS = 4;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] upvec_x;
    logic signed [31:0] upvec_y;
    logic signed [31:0] upvec_z;
  } lavm_in_t;

  typedef struct packed {
    logic signed [31:0] entry_row0;
    logic signed [31:0] entry_row1;
    logic signed [31:0] entry_row2;
    logic signed [31:0] entry_row3;
    logic [1:0]         column_index;
    logic               last_column;
    logic               degenerate;
  } lavm_out_t;

endpackage

@@ rtl/lavm_norm.sv @@
// ----------------------------------------------------------------------------
// lavm_norm
// Pipelined 3-vector normalizer: power-of-two prescale, sum of squares,
// one square-root digit per stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module lavm_norm #(
  parameter int FRAC_BITS = lavm_pkg::LAVM_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic [2:0][lavm_pkg::LAVM_MAG_W-1:0] in_mag,
  input  logic [2:0]                           in_neg,
  output logic                                 out_valid,
  output logic [2:0][FRAC_BITS+1:0]            out_unit,
  output logic                                 out_zero
);
  import lavm_pkg::*;

  localparam int MW   = LAVM_MAG_W;
  localparam int NW   = LAVM_NRM_W;
  localparam int PW   = $clog2(MW);
  localparam int RW   = NW + 1;        // root width
  localparam int SW   = 2 * RW;        // radicand width
  localparam int RMW  = RW + 2;        // sqrt remainder width
  localparam int SQ_N = RW;
  localparam int QW   = FRAC_BITS + 1; // quotient width
  localparam int NUMW = NW + FRAC_BITS + 1;
  localparam int UW   = FRAC_BITS + 2;

  // stage 1: input register
  logic                s1_v_r;
  logic [2:0][MW-1:0]  s1_mag_r;
  logic [2:0]          s1_neg_r;
  // stage 2: leading one
  logic                s2_v_r;
  logic [2:0][MW-1:0]  s2_mag_r;
  logic [2:0]          s2_neg_r;
  logic                s2_zero_r;
  logic [PW-1:0]       s2_lead_r;
  logic [PW-1:0]       lead_nxt;
  logic [MW-1:0]       top_or;
  // stage 3: prescaled magnitudes
  logic                s3_v_r;
  logic [2:0][NW-1:0]  s3_m_r;
  logic [2:0][NW-1:0]  m_nxt;
  logic [2:0]          s3_neg_r;
  logic                s3_zero_r;
  // stage 4: squares
  logic                s4_v_r;
  logic [2:0][NW-1:0]  s4_m_r;
  logic [2:0][2*NW-1:0] s4_sq_r;
  logic [2:0]          s4_neg_r;
  logic                s4_zero_r;

  // square root chain
  logic                sq_v_r    [0:SQ_N];
  logic [SW-1:0]       sq_rad_r  [0:SQ_N];
  logic [RW-1:0]       sq_root_r [0:SQ_N];
  logic [RMW-1:0]      sq_rem_r  [0:SQ_N];
  logic [2:0][NW-1:0]  sq_m_r    [0:SQ_N];
  logic [2:0]          sq_neg_r  [0:SQ_N];
  logic                sq_zero_r [0:SQ_N];

  // divider chain
  logic                dv_v_r    [0:QW];
  logic [RW-1:0]       dv_norm_r [0:QW];
  logic [2:0][RW-1:0]  dv_rem_r  [0:QW];
  logic [2:0][QW-1:0]  dv_lo_r   [0:QW];
  logic [2:0]          dv_neg_r  [0:QW];
  logic                dv_zero_r [0:QW];

  logic [2:0][RW-1:0]  rem0_nxt;
  logic [2:0][QW-1:0]  lo0_nxt;
  logic [2:0][UW-1:0]  unit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      sq_v_r[0] <= 1'b0;
      dv_v_r[0] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v_r    <= in_valid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      sq_v_r[0] <= s4_v_r;
      dv_v_r[0] <= sq_v_r[SQ_N];
      out_valid <= dv_v_r[QW];
    end
  end

  always_comb begin
    top_or   = s1_mag_r[0] | s1_mag_r[1] | s1_mag_r[2];
    lead_nxt = '0;
    for (int b = 0; b < MW; b++) begin
      if (top_or[b]) lead_nxt = PW'(b);
    end
  end

  // shift so the largest magnitude has its top bit at NW-1
  always_comb begin
    logic [MW-1:0] tmp;
    logic [PW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      if (s2_lead_r >= PW'(NW - 1)) begin
        sh  = s2_lead_r - PW'(NW - 1);
        tmp = s2_mag_r[i] >> sh;
      end else begin
        sh  = PW'(NW - 1) - s2_lead_r;
        tmp = s2_mag_r[i] << sh;
      end
      m_nxt[i] = tmp[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s1_mag_r  <= in_mag;
    s1_neg_r  <= in_neg;
    s2_mag_r  <= s1_mag_r;
    s2_neg_r  <= s1_neg_r;
    s2_zero_r <= (top_or == '0);
    s2_lead_r <= lead_nxt;
    s3_m_r    <= m_nxt;
    s3_neg_r  <= s2_neg_r;
    s3_zero_r <= s2_zero_r;
    s4_m_r    <= s3_m_r;
    s4_neg_r  <= s3_neg_r;
    s4_zero_r <= s3_zero_r;
    for (int i = 0; i < 3; i++) begin
      s4_sq_r[i] <= s3_m_r[i] * s3_m_r[i];
    end
    sq_rad_r[0]  <= SW'(s4_sq_r[0]) + SW'(s4_sq_r[1]) + SW'(s4_sq_r[2]);
    sq_root_r[0] <= '0;
    sq_rem_r[0]  <= '0;
    sq_m_r[0]    <= s4_m_r;
    sq_neg_r[0]  <= s4_neg_r;
    sq_zero_r[0] <= s4_zero_r;
  end

  // one root digit per stage
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [RMW+1:0] rem2;
    logic [RMW+1:0] trial;
    logic           ge;

    always_comb begin
      rem2  = {sq_rem_r[k], sq_rad_r[k][SW-1:SW-2]};
      trial = (RMW+2)'({sq_root_r[k], 2'b01});
      ge    = (rem2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_rad_r[k+1]  <= {sq_rad_r[k][SW-3:0], 2'b00};
      sq_root_r[k+1] <= {sq_root_r[k][RW-2:0], ge};
      sq_rem_r[k+1]  <= ge ? RMW'(rem2 - trial) : RMW'(rem2);
      sq_m_r[k+1]    <= sq_m_r[k];
      sq_neg_r[k+1]  <= sq_neg_r[k];
      sq_zero_r[k+1] <= sq_zero_r[k];
    end
  end

  // numerator = (m << FRAC_BITS) + norm/2, split into high remainder and low bits
  always_comb begin
    logic [NUMW-1:0] num;
    for (int i = 0; i < 3; i++) begin
      num         = {1'b0, sq_m_r[SQ_N][i], {FRAC_BITS{1'b0}}}
                    + NUMW'(sq_root_r[SQ_N] >> 1);
      rem0_nxt[i] = RW'(num[NUMW-1:QW]);
      lo0_nxt[i]  = num[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    dv_norm_r[0] <= sq_root_r[SQ_N];
    dv_rem_r[0]  <= rem0_nxt;
    dv_lo_r[0]   <= lo0_nxt;
    dv_neg_r[0]  <= sq_neg_r[SQ_N];
    dv_zero_r[0] <= sq_zero_r[SQ_N];
  end

  // one quotient bit per stage, three lanes
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [2:0][RW-1:0] rem_nxt;
    logic [2:0][QW-1:0] lo_nxt;

    always_comb begin
      logic [RW:0] rem2;
      logic        ge;
      for (int i = 0; i < 3; i++) begin
        rem2       = {dv_rem_r[k][i], dv_lo_r[k][i][QW-1]};
        ge         = (rem2 >= {1'b0, dv_norm_r[k]});
        rem_nxt[i] = ge ? RW'(rem2 - {1'b0, dv_norm_r[k]}) : RW'(rem2);
        lo_nxt[i]  = {dv_lo_r[k][i][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_norm_r[k+1] <= dv_norm_r[k];
      dv_rem_r[k+1]  <= rem_nxt;
      dv_lo_r[k+1]   <= lo_nxt;
      dv_neg_r[k+1]  <= dv_neg_r[k];
      dv_zero_r[k+1] <= dv_zero_r[k];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_nxt[i] = dv_neg_r[QW][i] ? UW'(-UW'(dv_lo_r[QW][i])) : UW'(dv_lo_r[QW][i]);
    end
  end

  always_ff @(posedge clk) begin
    out_unit <= unit_nxt;
    out_zero <= dv_zero_r[QW];
  end

endmodule

@@ rtl/look_at_view_matrix_top.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// Right-handed look-at view matrix builder in signed fixed point.
// ----------------------------------------------------------------------------
// A build is accepted when start is high and busy is low; the 4x4 matrix
// comes back as four column beats on consecutive cycles, column 0 first,
// each marked by out_valid for one cycle. The receiver cannot stall, so
// out_item must be captured whenever out_valid is high. After each accept,
// busy stays high while its gap counter runs down to zero, which spaces the
// builds to match the four output beats per matrix. Before out_valid for
// the first column rises, the forward and up normalizers run side by side,
// then the side normalizer follows, each with one square-root digit and
// one quotient bit per pipeline stage.
// Degenerate input yields the identity matrix with degenerate set.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top #(
  parameter int FRAC_BITS = lavm_pkg::LAVM_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lavm_pkg::lavm_in_t  in_item,
  output logic                out_valid,
  output lavm_pkg::lavm_out_t out_item
);
  import lavm_pkg::*;

  localparam int MW   = LAVM_MAG_W;
  localparam int UW   = FRAC_BITS + 2;   // unit vector component
  localparam int UUW  = UW + 1;          // recomputed up component
  localparam int PRW  = 2 * UW;          // unit x unit product
  localparam int CW   = PRW + 1;         // cross product component
  localparam int EPW  = UUW + 32;        // component x eye product
  localparam int DW   = FRAC_BITS + 36;  // dot sums
  localparam int NLAT = FRAC_BITS + 39;  // normalizer latency
  localparam logic [1:0] LAST_COL = 2'(LAVM_COLS - 1);
  localparam logic signed [DW-1:0] ONE  = {{(DW-FRAC_BITS-1){1'b0}}, 1'b1,
                                           {FRAC_BITS{1'b0}}};
  localparam logic signed [DW-1:0] MAXV = {{(DW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [DW-1:0] MINV = {{(DW-31){1'b1}}, {31{1'b0}}};

  function automatic logic signed [DW-1:0] rnd(input logic signed [DW-1:0] x);
    logic [DW-1:0] mag;
    logic [DW-1:0] r;
    mag = x[DW-1] ? DW'(-x) : DW'(x);
    r   = (mag + (DW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[DW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [31:0] sat(input logic signed [DW-1:0] x);
    logic [31:0] r;
    if (x > MAXV) begin
      r = 32'h7fff_ffff;
    end else if (x < MINV) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // input throttle: one build per four output beats
  logic [1:0] gap_r;
  logic       accept;

  assign busy   = (gap_r != 2'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 2'd0;
    end else if (accept) begin
      gap_r <= LAST_COL;
    end else if (gap_r != 2'd0) begin
      gap_r <= gap_r - 2'd1;
    end
  end

  // T0 / T1: capture, then differences
  logic                     t0_v_r;
  lavm_in_t                 t0_item_r;
  logic                     t1_v_r;
  logic signed [32:0]       d_r  [3];
  logic signed [31:0]       up_r [3];
  logic [2:0][31:0]         eye_dly_r [0:NLAT];
  logic [2:0][MW-1:0]       dmag;
  logic [2:0][MW-1:0]       umag;
  logic [2:0]               dneg;
  logic [2:0]               uneg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r <= 1'b0;
      t1_v_r <= 1'b0;
    end else begin
      t0_v_r <= accept;
      t1_v_r <= t0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    t0_item_r    <= in_item;
    d_r[0]       <= 33'(t0_item_r.target_x) - 33'(t0_item_r.eye_x);
    d_r[1]       <= 33'(t0_item_r.target_y) - 33'(t0_item_r.eye_y);
    d_r[2]       <= 33'(t0_item_r.target_z) - 33'(t0_item_r.eye_z);
    up_r[0]      <= t0_item_r.upvec_x;
    up_r[1]      <= t0_item_r.upvec_y;
    up_r[2]      <= t0_item_r.upvec_z;
    eye_dly_r[0] <= {t0_item_r.eye_z, t0_item_r.eye_y, t0_item_r.eye_x};
  end

  always_comb begin
    logic signed [32:0] ue;
    for (int i = 0; i < 3; i++) begin
      dneg[i] = d_r[i][32];
      dmag[i] = MW'(dneg[i] ? 33'(-d_r[i]) : 33'(d_r[i]));
      ue      = 33'(up_r[i]);
      uneg[i] = ue[32];
      umag[i] = MW'(uneg[i] ? 33'(-ue) : 33'(ue));
    end
  end

  for (genvar k = 0; k < NLAT; k++) begin : g_eye_dly
    always_ff @(posedge clk) begin
      eye_dly_r[k+1] <= eye_dly_r[k];
    end
  end

  logic                nd_v;
  logic [2:0][UW-1:0]  nd_unit;
  logic                nd_zero;
  logic [2:0][UW-1:0]  nu_unit;
  logic                nu_zero;

  lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t1_v_r),
    .in_mag    (dmag),
    .in_neg    (dneg),
    .out_valid (nd_v),
    .out_unit  (nd_unit),
    .out_zero  (nd_zero)
  );

  lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_up (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t1_v_r),
    .in_mag    (umag),
    .in_neg    (uneg),
    .out_valid (),
    .out_unit  (nu_unit),
    .out_zero  (nu_zero)
  );

  // C1 / C2: f x u0
  logic                     c1_v_r;
  logic signed [PRW-1:0]    c1_p_r [6];
  logic [2:0][UW-1:0]       c1_f_r;
  logic [2:0][31:0]         c1_eye_r;
  logic                     c1_deg_r;
  logic                     c2_v_r;
  logic signed [CW-1:0]     c2_c_r [3];
  logic [2:0][UW-1:0]       cf_dly_r  [0:NLAT];
  logic [2:0][31:0]         ce_dly_r  [0:NLAT];
  logic                     cd_dly_r  [0:NLAT];
  logic [2:0][MW-1:0]       cmag;
  logic [2:0]               cneg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
    end else begin
      c1_v_r <= nd_v;
      c2_v_r <= c1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_p_r[0]   <= $signed(nd_unit[1]) * $signed(nu_unit[2]);
    c1_p_r[1]   <= $signed(nd_unit[2]) * $signed(nu_unit[1]);
    c1_p_r[2]   <= $signed(nd_unit[2]) * $signed(nu_unit[0]);
    c1_p_r[3]   <= $signed(nd_unit[0]) * $signed(nu_unit[2]);
    c1_p_r[4]   <= $signed(nd_unit[0]) * $signed(nu_unit[1]);
    c1_p_r[5]   <= $signed(nd_unit[1]) * $signed(nu_unit[0]);
    c1_f_r      <= nd_unit;
    c1_eye_r    <= eye_dly_r[NLAT];
    c1_deg_r    <= nd_zero || nu_zero;
    c2_c_r[0]   <= CW'(c1_p_r[0]) - CW'(c1_p_r[1]);
    c2_c_r[1]   <= CW'(c1_p_r[2]) - CW'(c1_p_r[3]);
    c2_c_r[2]   <= CW'(c1_p_r[4]) - CW'(c1_p_r[5]);
    cf_dly_r[0] <= c1_f_r;
    ce_dly_r[0] <= c1_eye_r;
    cd_dly_r[0] <= c1_deg_r;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cneg[i] = c2_c_r[i][CW-1];
      cmag[i] = MW'(cneg[i] ? CW'(-c2_c_r[i]) : CW'(c2_c_r[i]));
    end
  end

  for (genvar k = 0; k < NLAT; k++) begin : g_side_dly
    always_ff @(posedge clk) begin
      cf_dly_r[k+1] <= cf_dly_r[k];
      ce_dly_r[k+1] <= ce_dly_r[k];
      cd_dly_r[k+1] <= cd_dly_r[k];
    end
  end

  logic                ns_v;
  logic [2:0][UW-1:0]  ns_unit;
  logic                ns_zero;

  lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_side (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c2_v_r),
    .in_mag    (cmag),
    .in_neg    (cneg),
    .out_valid (ns_v),
    .out_unit  (ns_unit),
    .out_zero  (ns_zero)
  );

  // P1..P6: u = s x f, dot products with eye
  logic                     p1_v_r, p2_v_r, p3_v_r, p4_v_r, p5_v_r, p6_v_r;
  logic signed [PRW-1:0]    p1_q_r  [6];
  logic signed [EPW-1:0]    p1_se_r [3];
  logic signed [EPW-1:0]    p1_fe_r [3];
  logic [2:0][UW-1:0]       p1_s_r, p2_s_r, p3_s_r, p4_s_r, p5_s_r, p6_s_r;
  logic [2:0][UW-1:0]       p1_f_r, p2_f_r, p3_f_r, p4_f_r, p5_f_r, p6_f_r;
  logic [2:0][31:0]         p1_eye_r, p2_eye_r, p3_eye_r;
  logic                     p1_deg_r, p2_deg_r, p3_deg_r, p4_deg_r, p5_deg_r, p6_deg_r;
  logic signed [CW-1:0]     p2_cu_r [3];
  logic signed [DW-1:0]     p2_sd_r, p2_fd_r;
  logic signed [UUW-1:0]    p3_u_r [3];
  logic signed [UUW-1:0]    p4_u_r [3];
  logic signed [UUW-1:0]    p5_u_r [3];
  logic signed [UUW-1:0]    p6_u_r [3];
  logic signed [DW-1:0]     p3_sd_r, p3_fd_r, p4_sd_r, p4_fd_r;
  logic signed [DW-1:0]     p5_sd_r, p5_fd_r, p6_sd_r, p6_fd_r;
  logic signed [EPW-1:0]    p4_ue_r [3];
  logic signed [DW-1:0]     p5_ud_r, p6_ud_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
      p5_v_r <= 1'b0;
      p6_v_r <= 1'b0;
    end else begin
      p1_v_r <= ns_v;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
      p5_v_r <= p4_v_r;
      p6_v_r <= p5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    // P1
    p1_q_r[0] <= $signed(ns_unit[1]) * $signed(cf_dly_r[NLAT][2]);
    p1_q_r[1] <= $signed(ns_unit[2]) * $signed(cf_dly_r[NLAT][1]);
    p1_q_r[2] <= $signed(ns_unit[2]) * $signed(cf_dly_r[NLAT][0]);
    p1_q_r[3] <= $signed(ns_unit[0]) * $signed(cf_dly_r[NLAT][2]);
    p1_q_r[4] <= $signed(ns_unit[0]) * $signed(cf_dly_r[NLAT][1]);
    p1_q_r[5] <= $signed(ns_unit[1]) * $signed(cf_dly_r[NLAT][0]);
    for (int i = 0; i < 3; i++) begin
      p1_se_r[i] <= $signed(ns_unit[i]) * $signed(ce_dly_r[NLAT][i]);
      p1_fe_r[i] <= $signed(cf_dly_r[NLAT][i]) * $signed(ce_dly_r[NLAT][i]);
    end
    p1_s_r   <= ns_unit;
    p1_f_r   <= cf_dly_r[NLAT];
    p1_eye_r <= ce_dly_r[NLAT];
    p1_deg_r <= cd_dly_r[NLAT] || ns_zero;
    // P2
    p2_cu_r[0] <= CW'(p1_q_r[0]) - CW'(p1_q_r[1]);
    p2_cu_r[1] <= CW'(p1_q_r[2]) - CW'(p1_q_r[3]);
    p2_cu_r[2] <= CW'(p1_q_r[4]) - CW'(p1_q_r[5]);
    p2_sd_r    <= DW'(p1_se_r[0]) + DW'(p1_se_r[1]) + DW'(p1_se_r[2]);
    p2_fd_r    <= DW'(p1_fe_r[0]) + DW'(p1_fe_r[1]) + DW'(p1_fe_r[2]);
    p2_s_r     <= p1_s_r;
    p2_f_r     <= p1_f_r;
    p2_eye_r   <= p1_eye_r;
    p2_deg_r   <= p1_deg_r;
    // P3
    for (int i = 0; i < 3; i++) begin
      p3_u_r[i] <= UUW'(rnd(DW'(p2_cu_r[i])));
    end
    p3_sd_r  <= rnd(p2_sd_r);
    p3_fd_r  <= rnd(p2_fd_r);
    p3_s_r   <= p2_s_r;
    p3_f_r   <= p2_f_r;
    p3_eye_r <= p2_eye_r;
    p3_deg_r <= p2_deg_r;
    // P4
    for (int i = 0; i < 3; i++) begin
      p4_ue_r[i] <= p3_u_r[i] * $signed(p3_eye_r[i]);
    end
    p4_u_r   <= p3_u_r;
    p4_sd_r  <= p3_sd_r;
    p4_fd_r  <= p3_fd_r;
    p4_s_r   <= p3_s_r;
    p4_f_r   <= p3_f_r;
    p4_deg_r <= p3_deg_r;
    // P5
    p5_ud_r  <= DW'(p4_ue_r[0]) + DW'(p4_ue_r[1]) + DW'(p4_ue_r[2]);
    p5_u_r   <= p4_u_r;
    p5_sd_r  <= p4_sd_r;
    p5_fd_r  <= p4_fd_r;
    p5_s_r   <= p4_s_r;
    p5_f_r   <= p4_f_r;
    p5_deg_r <= p4_deg_r;
    // P6
    p6_ud_r  <= rnd(p5_ud_r);
    p6_u_r   <= p5_u_r;
    p6_sd_r  <= p5_sd_r;
    p6_fd_r  <= p5_fd_r;
    p6_s_r   <= p5_s_r;
    p6_f_r   <= p5_f_r;
    p6_deg_r <= p5_deg_r;
  end

  // matrix assembly and column serializer
  logic [3:0][3:0][31:0] mat_nxt;
  logic [3:0][3:0][31:0] mat_r;
  logic                  deg_r;
  logic [1:0]            oc_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mat_nxt[j][0] = sat(DW'($signed(p6_s_r[j])));
      mat_nxt[j][1] = sat(DW'(p6_u_r[j]));
      mat_nxt[j][2] = sat(-DW'($signed(p6_f_r[j])));
      mat_nxt[j][3] = '0;
    end
    mat_nxt[3][0] = sat(-p6_sd_r);
    mat_nxt[3][1] = sat(-p6_ud_r);
    mat_nxt[3][2] = sat(p6_fd_r);
    mat_nxt[3][3] = sat(ONE);
    if (p6_deg_r) begin
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 4; i++) begin
          mat_nxt[j][i] = (i == j) ? sat(ONE) : 32'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      oc_r      <= 2'd0;
    end else if (p6_v_r) begin
      out_valid <= 1'b1;
      oc_r      <= 2'd0;
    end else if (out_valid) begin
      oc_r <= oc_r + 2'd1;
      if (oc_r == LAST_COL) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p6_v_r) begin
      mat_r <= mat_nxt;
      deg_r <= p6_deg_r;
    end
  end

  always_comb begin
    out_item.entry_row0   = mat_r[oc_r][0];
    out_item.entry_row1   = mat_r[oc_r][1];
    out_item.entry_row2   = mat_r[oc_r][2];
    out_item.entry_row3   = mat_r[oc_r][3];
    out_item.column_index = oc_r;
    out_item.last_column  = (oc_r == LAST_COL);
    out_item.degenerate   = deg_r;
  end

endmodule
